// ----- design/blm_pkg.sv -----
// shared constants, widths and types of the block loudness meter
package blm_pkg;

  localparam int unsigned BLOCK_MAX = 128;
  localparam int unsigned LED_COUNT = 10;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned LEVEL_W  = 16;
  localparam int unsigned BAR_W    = 10;

  // level = abs_sum / (count * 2^FRAC_SHIFT)
  localparam int unsigned FRAC_SHIFT = 15;

  localparam int unsigned CNT_W = $clog2(BLOCK_MAX + 1);
  localparam int unsigned SUM_W = SAMPLE_W + $clog2(BLOCK_MAX);
  localparam int unsigned DVD_W = SUM_W - FRAC_SHIFT;

  // led_count^2 * level < 2^(LEVEL_W + 2*LED_K)
  localparam int unsigned LED_K  = $clog2(LED_COUNT + 1);
  localparam int unsigned X_W    = LEVEL_W + 2 * LED_K;
  localparam int unsigned ROOT_W = X_W / 2;
  localparam int unsigned LED_SQ = LED_COUNT * LED_COUNT;

  localparam int unsigned STEP_N = (DVD_W > ROOT_W) ? DVD_W : ROOT_W;
  localparam int unsigned STEP_W = $clog2(STEP_N);

  localparam logic [LEVEL_W-1:0] TRIG_RESET = LEVEL_W'(32768);

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
  } job_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [BAR_W-1:0]   led_bar;
    logic               loud;
  } result_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_SQRT = 5'b01000,
    ST_OUT  = 5'b10000
  } back_state_e;

endpackage

// ----- design/block_loudness_meter.sv -----
// top level of the block loudness meter
// Samples are taken one per cycle (push while full is low). The front end adds
// each sample's absolute value into a running sum and counts samples; a block
// closes on a sample marked block_end or on the BLOCK_MAX-th sample. Each closed
// block enters a two-entry queue, and the back end turns it into one result:
// level = mean |sample| as a Q0.16 fraction of 2^31 (saturated to 65535), a
// thermometer led bar of floor(10*sqrt(level/2^16)) lit bits, and loud when level
// exceeds trigger_level. The back end works on one block at a time with a
// bit-serial divider and square root, so short blocks arriving faster than it
// finishes them fill the queue and raise full. Results wait in an output
// register until popped.
// trigger_level resets to 32768 and should be written while the block is idle.
module block_loudness_meter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic signed [blm_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                block_end_i,
  output logic                                empty,
  input  logic                                pop,
  output logic [blm_pkg::LEVEL_W-1:0]         level_o,
  output logic [blm_pkg::BAR_W-1:0]           led_bar_o,
  output logic                                loud_o,
  input  logic                                cfg_we_i,
  input  logic [blm_pkg::LEVEL_W-1:0]         cfg_wdata_i
);

  logic [blm_pkg::LEVEL_W-1:0] trig_q;
  logic                        accept;
  logic                        job_wr;
  blm_pkg::job_t               job_in;
  logic                        job_full;
  logic                        job_empty;
  logic                        job_rd;
  blm_pkg::job_t               job_out;
  logic                        res_valid;
  blm_pkg::result_t            res;

  assign full   = job_full;
  assign accept = push && !job_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_q <= blm_pkg::TRIG_RESET;
    end else if (cfg_we_i) begin
      trig_q <= cfg_wdata_i;
    end
  end

  blm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .sample_i    (sample_i),
    .block_end_i (block_end_i),
    .job_valid_o (job_wr),
    .job_o       (job_in)
  );

  blm_job_fifo u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (job_wr),
    .wdata_i (job_in),
    .rd_i    (job_rd),
    .full_o  (job_full),
    .empty_o (job_empty),
    .rdata_o (job_out)
  );

  blm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_rd_o    (job_rd),
    .trig_i      (trig_q),
    .pop_i       (pop),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign empty     = !res_valid;
  assign level_o   = res.level;
  assign led_bar_o = res.led_bar;
  assign loud_o    = res.loud;

endmodule

// ----- design/blm_front.sv -----
// front end: absolute value accumulation and block closing
module blm_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [blm_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                          block_end_i,
  output logic                          job_valid_o,
  output blm_pkg::job_t                 job_o
);

  logic [blm_pkg::SUM_W-1:0]    sum_q, sum_d;
  logic [blm_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [blm_pkg::SAMPLE_W-1:0] mag;
  logic [blm_pkg::SUM_W-1:0]    sum_next;
  logic [blm_pkg::CNT_W-1:0]    cnt_next;
  logic                         close;

  // two's complement negate; the most negative sample maps to 2^31 as unsigned
  assign mag      = sample_i[blm_pkg::SAMPLE_W-1] ? (~sample_i + 1'b1) : sample_i;
  assign sum_next = sum_q + blm_pkg::SUM_W'(mag);
  assign cnt_next = cnt_q + 1'b1;
  assign close    = block_end_i || (cnt_next == blm_pkg::CNT_W'(blm_pkg::BLOCK_MAX));

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (accept_i) begin
      if (close) begin
        sum_d = '0;
        cnt_d = '0;
      end else begin
        sum_d = sum_next;
        cnt_d = cnt_next;
      end
    end
  end

  assign job_valid_o = accept_i && close;
  assign job_o.sum   = sum_next;
  assign job_o.cnt   = cnt_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- design/blm_job_fifo.sv -----
// two-entry queue of closed blocks between front and back
module blm_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  blm_pkg::job_t wdata_i,
  input  logic          rd_i,
  output logic          full_o,
  output logic          empty_o,
  output blm_pkg::job_t rdata_o
);

  blm_pkg::job_t mem_q [2];
  logic          wptr_q, wptr_d;
  logic          rptr_q, rptr_d;
  logic [1:0]    fill_q, fill_d;
  logic          do_wr, do_rd;

  assign full_o  = (fill_q == 2'd2);
  assign empty_o = (fill_q == 2'd0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    fill_d = fill_q;
    if (do_wr) begin
      wptr_d = ~wptr_q;
    end
    if (do_rd) begin
      rptr_d = ~rptr_q;
    end
    if (do_wr && !do_rd) begin
      fill_d = fill_q + 2'd1;
    end else if (do_rd && !do_wr) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ----- design/blm_back.sv -----
// back end: serial divide, square root, led bar and result register
module blm_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_empty_i,
  input  blm_pkg::job_t                 job_i,
  output logic                          job_rd_o,
  input  logic [blm_pkg::LEVEL_W-1:0]   trig_i,
  input  logic                          pop_i,
  output logic                          res_valid_o,
  output blm_pkg::result_t              res_o
);

  localparam int unsigned RW = blm_pkg::ROOT_W;
  localparam int unsigned CW = blm_pkg::CNT_W;
  localparam int unsigned DW = blm_pkg::DVD_W;
  localparam int unsigned XW = blm_pkg::X_W;
  localparam int unsigned KW = blm_pkg::LED_K;
  localparam int unsigned LW = blm_pkg::LEVEL_W;

  blm_pkg::back_state_e        state_q, state_d;
  logic [blm_pkg::STEP_W-1:0]  step_q, step_d;
  logic                        res_valid_q, res_valid_d;
  blm_pkg::result_t            res_q, res_d;

  logic [DW-1:0]   dq_q, dq_d;
  logic [CW-1:0]   div_q, div_d;
  logic [CW-1:0]   drem_q, drem_d;
  logic [LW-1:0]   level_q, level_d;
  logic [XW-1:0]   x_q, x_d;
  logic [RW-1:0]   root_q, root_d;
  logic [RW+1:0]   srem_q, srem_d;

  logic [CW:0]     t_div;
  logic            div_ge;
  logic [DW-1:0]   dq_step;
  logic [RW+3:0]   t_sq;
  logic [RW+3:0]   trial;
  logic            sq_ge;
  logic [KW-1:0]   n_raw, n_led;
  logic            load;

  // restoring divide, one quotient bit per cycle
  assign t_div   = {drem_q, dq_q[DW-1]};
  assign div_ge  = (t_div >= {1'b0, div_q});
  assign dq_step = {dq_q[DW-2:0], div_ge};

  // digit-by-digit square root, one root bit per cycle
  assign t_sq  = {srem_q, x_q[XW-1:XW-2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign sq_ge = (t_sq >= trial);

  assign n_raw = root_q[RW-1:8];
  assign n_led = (n_raw > KW'(blm_pkg::LED_COUNT)) ? KW'(blm_pkg::LED_COUNT) : n_raw;

  assign load = (state_q == blm_pkg::ST_OUT) && (!res_valid_q || pop_i);

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    dq_d     = dq_q;
    div_d    = div_q;
    drem_d   = drem_q;
    level_d  = level_q;
    x_d      = x_q;
    root_d   = root_q;
    srem_d   = srem_q;
    job_rd_o = 1'b0;
    res_d    = res_q;

    case (state_q)
      blm_pkg::ST_IDLE: begin
        if (!job_empty_i) begin
          job_rd_o = 1'b1;
          dq_d     = job_i.sum[blm_pkg::SUM_W-1:blm_pkg::FRAC_SHIFT];
          div_d    = job_i.cnt;
          drem_d   = '0;
          step_d   = blm_pkg::STEP_W'(DW - 1);
          state_d  = blm_pkg::ST_DIV;
        end
      end
      blm_pkg::ST_DIV: begin
        dq_d   = dq_step;
        drem_d = div_ge ? CW'(t_div - {1'b0, div_q}) : t_div[CW-1:0];
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          // saturate the quotient to the level range
          level_d = (|dq_step[DW-1:LW]) ? {LW{1'b1}} : dq_step[LW-1:0];
          state_d = blm_pkg::ST_MUL;
        end
      end
      blm_pkg::ST_MUL: begin
        x_d     = XW'(blm_pkg::LED_SQ) * XW'(level_q);
        root_d  = '0;
        srem_d  = '0;
        step_d  = blm_pkg::STEP_W'(RW - 1);
        state_d = blm_pkg::ST_SQRT;
      end
      blm_pkg::ST_SQRT: begin
        srem_d = sq_ge ? (RW + 2)'(t_sq - trial) : t_sq[RW+1:0];
        root_d = {root_q[RW-2:0], sq_ge};
        x_d    = x_q << 2;
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          state_d = blm_pkg::ST_OUT;
        end
      end
      blm_pkg::ST_OUT: begin
        if (load) begin
          res_d.level   = level_q;
          res_d.led_bar = ~({blm_pkg::BAR_W{1'b1}} << n_led);
          res_d.loud    = (level_q > trig_i);
          state_d       = blm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = blm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (load) begin
      res_valid_d = 1'b1;
    end else if (pop_i) begin
      res_valid_d = 1'b0;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= blm_pkg::ST_IDLE;
      step_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q    <= dq_d;
    div_q   <= div_d;
    drem_q  <= drem_d;
    level_q <= level_d;
    x_q     <= x_d;
    root_q  <= root_d;
    srem_q  <= srem_d;
    res_q   <= res_d;
  end

endmodule
